// File: src/pdqm_pkg.sv
package pdqm_pkg;

	// default sizes
	localparam int NUM_DEST_DEF    = 16;
	localparam int QUEUE_DEPTH_DEF = 64;

	localparam logic [23:0] TOTAL_MAX     = 24'hFFFFFF;
	localparam logic [23:0] MAX_BITS_RST  = 24'd65536;

	// operation codes
	localparam logic [2:0] OP_ENQUEUE = 3'd0;
	localparam logic [2:0] OP_REQUEUE = 3'd1;
	localparam logic [2:0] OP_DEQUEUE = 3'd2;
	localparam logic [2:0] OP_PROBE   = 3'd3;
	localparam logic [2:0] OP_RX_CUR  = 3'd4;
	localparam logic [2:0] OP_RX_ADV  = 3'd5;
	localparam logic [2:0] OP_REARM   = 3'd6;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OVER  = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_BITS = 2'd0;
	localparam logic [1:0] CFG_FLUSH    = 2'd1;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  dest;
		logic [15:0] packet_handle;
		logic [15:0] length_bits;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        accepted;
		logic [15:0] out_handle;
		logic [15:0] out_length;
		logic        has_queue;
		logic        has_packets;
		logic [23:0] queued_total;
		logic [3:0]  receiver;
		logic        receiver_valid;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REC,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

// File: src/pdqm_rr_scan.sv
module pdqm_rr_scan #(
	parameter int NUM_DEST = 16,
	localparam int DW = $clog2(NUM_DEST)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [DW-1:0]       start,
	input  logic [NUM_DEST-1:0] nonempty,
	output logic                done,
	output logic                found,
	output logic [DW-1:0]       idx
);
	import pdqm_pkg::*;

	logic          busy_q;
	logic [DW-1:0] idx_q;
	logic [DW-1:0] cnt_q;
	logic          hit;
	logic          last;

	// one candidate per cycle, in index order with wrap
	assign hit   = nonempty[idx_q];
	assign last  = (cnt_q == DW'(NUM_DEST - 1));
	assign done  = busy_q && (hit || last);
	assign found = busy_q && hit;
	assign idx   = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			idx_q  <= start;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (hit || last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= (idx_q == DW'(NUM_DEST - 1)) ? '0 : idx_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

// File: src/per_destination_queue_manager.sv
// channel  | direction | handshake               | payload
// req      | in        | req_valid / req_stall   | pdqm_pkg::req_t
// rsp      | out       | rsp_valid / rsp_stall   | pdqm_pkg::rsp_t
// cfg      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a queue operation passes through accept (queue record read), record
// stage (descriptor read) and commit; receiver searches add a pass through
// the round-robin scanner, which visits up to NUM_DEST indexes
// one transaction in flight; req_stall is high from accept to commit
// commit waits while a finished result is held by rsp_stall
// reset clears all queues, the receiver and the registers; no clearing pass
module per_destination_queue_manager #(
	parameter int NUM_DEST    = pdqm_pkg::NUM_DEST_DEF,
	parameter int QUEUE_DEPTH = pdqm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pdqm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pdqm_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [23:0]    cfg_data
);
	import pdqm_pkg::*;

	localparam int DW = $clog2(NUM_DEST);
	localparam int PW = $clog2(QUEUE_DEPTH);

	// configuration
	logic [23:0] max_bits_q;
	logic        flush_on_start_q;

	// sequencer
	state_t state_q, state_d;

	// accepted transaction
	req_t          req_q;
	logic [DW-1:0] d_q;
	logic          dv_q;

	// per destination record memories, valid bits mark written entries
	logic                exists_mem [NUM_DEST];
	logic                armed_mem  [NUM_DEST];
	logic [23:0]         total_mem  [NUM_DEST];
	logic [PW-1:0]       head_mem   [NUM_DEST];
	logic [PW:0]         count_mem  [NUM_DEST];
	logic [NUM_DEST-1:0] rv_q;
	logic [NUM_DEST-1:0] ne_q;

	logic          ex_rd_q, arm_rd_q;
	logic [23:0]   tot_rd_q;
	logic [PW-1:0] head_rd_q;
	logic [PW:0]   cnt_rd_q;

	// record stage
	logic          ex_q, arm_q;
	logic [23:0]   tot_q;
	logic [PW-1:0] head_q;
	logic [PW:0]   cnt_q;
	logic [PW-1:0] slot_q;

	// descriptor store
	logic [31:0] desc_mem [NUM_DEST << PW];
	logic [31:0] desc_q;

	// receiver pointer
	logic          rx_valid_q;
	logic [DW-1:0] rx_q;

	// scanner
	logic          scan_go, scan_done, scan_found;
	logic [DW-1:0] scan_start, scan_idx;

	logic          accept, commit, out_free;
	logic [DW-1:0] d_in;
	logic          ex_c, arm_c;
	logic [23:0]   tot_c;
	logic [PW-1:0] head_c, slot_c;
	logic [PW:0]   cnt_c, tail_sum;

	// commit values
	logic          n_ex, n_arm;
	logic [23:0]   n_tot;
	logic [PW-1:0] n_head;
	logic [PW:0]   n_cnt;
	logic          wr_rec, wr_desc;
	logic [1:0]    stat;
	logic          acc;
	logic [15:0]   oh, ol;
	logic [24:0]   sum_add, sum_probe;
	logic [23:0]   tot_sat, tot_probe;
	logic          full;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid || !rsp_stall;
	assign d_in      = DW'(req.dest);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bits_q       <= MAX_BITS_RST;
			flush_on_start_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_BITS: max_bits_q <= cfg_data;
				CFG_FLUSH:    flush_on_start_q <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer strobes
	always_comb begin
		state_d = state_q;
		scan_go = 1'b0;
		commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_REC;
			end
			S_REC: begin
				if (req_q.operation == OP_RX_CUR && rx_valid_q && ne_q[rx_q]) begin
					state_d = S_DONE;
				end else if (req_q.operation == OP_RX_CUR || req_q.operation == OP_RX_ADV) begin
					scan_go = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (scan_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// latch the transaction and read the queue record
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req;
			d_q       <= d_in;
			dv_q      <= ({28'd0, req.dest} < 32'(NUM_DEST));
			ex_rd_q   <= exists_mem[d_in];
			arm_rd_q  <= armed_mem[d_in];
			tot_rd_q  <= total_mem[d_in];
			head_rd_q <= head_mem[d_in];
			cnt_rd_q  <= count_mem[d_in];
		end
	end

	// an unwritten record reads as an absent, empty queue
	assign ex_c   = rv_q[d_q] && ex_rd_q;
	assign arm_c  = rv_q[d_q] && arm_rd_q;
	assign tot_c  = rv_q[d_q] ? tot_rd_q : '0;
	assign head_c = rv_q[d_q] ? head_rd_q : '0;
	assign cnt_c  = rv_q[d_q] ? cnt_rd_q : '0;

	// descriptor slot: tail for enqueue, slot before head for requeue, else head
	assign tail_sum = {1'b0, head_c} + cnt_c;
	always_comb begin
		case (req_q.operation)
			OP_ENQUEUE: slot_c = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
				PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
			OP_REQUEUE: slot_c = (head_c == '0) ? PW'(QUEUE_DEPTH - 1) : head_c - 1'b1;
			default:    slot_c = head_c;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REC) begin
			ex_q   <= ex_c;
			arm_q  <= arm_c;
			tot_q  <= tot_c;
			head_q <= head_c;
			cnt_q  <= cnt_c;
			slot_q <= slot_c;
			desc_q <= desc_mem[{d_q, slot_c}];
		end
	end

	// saturating total arithmetic
	assign sum_add   = {1'b0, tot_q} + {9'd0, req_q.length_bits};
	assign tot_sat   = sum_add[24] ? TOTAL_MAX : sum_add[23:0];
	assign tot_probe = arm_q ? '0 : tot_q;
	assign sum_probe = {1'b0, tot_probe} + {9'd0, req_q.length_bits};
	assign full      = (cnt_q >= (PW+1)'(QUEUE_DEPTH));

	always_comb begin
		n_ex    = ex_q;
		n_arm   = arm_q;
		n_tot   = tot_q;
		n_head  = head_q;
		n_cnt   = cnt_q;
		wr_rec  = 1'b0;
		wr_desc = 1'b0;
		stat    = STAT_OK;
		acc     = 1'b0;
		oh      = '0;
		ol      = '0;
		case (req_q.operation)
			OP_ENQUEUE: begin
				if (!dv_q) begin
					stat = STAT_EMPTY;
				end else if (ex_q && sum_add > {1'b0, max_bits_q}) begin
					stat = STAT_OVER;
				end else begin
					wr_rec = 1'b1;
					if (!ex_q) begin
						n_ex  = 1'b1;
						n_arm = flush_on_start_q;
					end
					if (full) begin
						stat = STAT_FULL;
					end else begin
						wr_desc = 1'b1;
						n_cnt   = cnt_q + 1'b1;
						n_tot   = tot_sat;
						acc     = 1'b1;
					end
				end
			end
			OP_REQUEUE: begin
				if (!dv_q) begin
					stat = STAT_EMPTY;
				end else begin
					wr_rec = 1'b1;
					if (!ex_q) begin
						n_ex  = 1'b1;
						n_arm = 1'b0;
					end
					if (full) begin
						stat = STAT_FULL;
					end else begin
						wr_desc = 1'b1;
						n_head  = slot_q;
						n_cnt   = cnt_q + 1'b1;
						n_tot   = tot_sat;
					end
				end
			end
			OP_DEQUEUE: begin
				if (!dv_q || !ex_q || cnt_q == '0) begin
					stat = STAT_EMPTY;
				end else begin
					wr_rec = 1'b1;
					oh     = desc_q[31:16];
					ol     = desc_q[15:0];
					n_head = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					n_cnt  = cnt_q - 1'b1;
					n_tot  = (tot_q > {8'd0, desc_q[15:0]}) ?
						tot_q - {8'd0, desc_q[15:0]} : '0;
				end
			end
			OP_PROBE: begin
				if (!dv_q) begin
					stat = STAT_EMPTY;
				end else if (!ex_q) begin
					stat = STAT_EMPTY;
					acc  = 1'b1;
				end else begin
					wr_rec = 1'b1;
					// armed flush empties the queue on this first probe
					if (arm_q) begin
						n_arm  = 1'b0;
						n_cnt  = '0;
						n_head = '0;
						n_tot  = '0;
					end
					acc = (sum_probe <= {1'b0, max_bits_q}) &&
						(n_cnt < (PW+1)'(QUEUE_DEPTH));
					if (n_cnt != '0) begin
						ol = desc_q[15:0];
					end else begin
						stat = STAT_EMPTY;
					end
				end
			end
			OP_RX_CUR, OP_RX_ADV: begin
				stat = rx_valid_q ? STAT_OK : STAT_EMPTY;
			end
			OP_REARM: begin
				if (!dv_q) begin
					stat = STAT_EMPTY;
				end else begin
					wr_rec = 1'b1;
					n_ex   = 1'b1;
					n_arm  = flush_on_start_q;
				end
			end
			default: ;
		endcase
	end

	// record and descriptor writes at commit
	always_ff @(posedge clk) begin
		if (commit && wr_rec) begin
			exists_mem[d_q] <= n_ex;
			armed_mem[d_q]  <= n_arm;
			total_mem[d_q]  <= n_tot;
			head_mem[d_q]   <= n_head;
			count_mem[d_q]  <= n_cnt;
		end
		if (commit && wr_desc) begin
			desc_mem[{d_q, slot_q}] <= {req_q.packet_handle, req_q.length_bits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= '0;
			ne_q <= '0;
		end else if (commit && wr_rec) begin
			rv_q[d_q] <= 1'b1;
			ne_q[d_q] <= (n_cnt != '0);
		end
	end

	// round-robin receiver: search starts after the current one, or at index 0 when none is valid
	assign scan_start = !rx_valid_q ? '0 :
		(rx_q == DW'(NUM_DEST - 1)) ? '0 : rx_q + 1'b1;

	pdqm_rr_scan #(
		.NUM_DEST (NUM_DEST)
	) u_rr_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (scan_go),
		.start    (scan_start),
		.nonempty (ne_q),
		.done     (scan_done),
		.found    (scan_found),
		.idx      (scan_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_q <= 1'b0;
			rx_q       <= '0;
		end else if (state_q == S_SCAN && scan_done) begin
			rx_valid_q <= scan_found;
			rx_q       <= scan_found ? scan_idx : '0;
		end
	end

	// result register, parts the commit from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (commit) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp.status         <= stat;
			rsp.accepted       <= acc;
			rsp.out_handle     <= oh;
			rsp.out_length     <= ol;
			rsp.has_queue      <= dv_q && n_ex;
			rsp.has_packets    <= dv_q && (n_cnt != '0);
			rsp.queued_total   <= dv_q ? n_tot : '0;
			rsp.receiver       <= 4'(rx_q);
			rsp.receiver_valid <= rx_valid_q;
		end
	end

`ifndef ASSERT_OFF
	a_accept_to_rec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_REC)
		else $error("accepted transaction did not enter record stage");

	a_rx_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_valid_q |-> rx_q == '0)
		else $error("invalid receiver with non-zero index");

	a_no_write_bad_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && wr_rec) |-> dv_q)
		else $error("record write for out of range destination");

	a_nonempty_written: assert property (@(posedge clk) disable iff (!arst_n)
		(ne_q & ~rv_q) == '0)
		else $error("non-empty flag on unwritten record");

	a_commit_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid && state_q == S_IDLE)
		else $error("commit without result");
`endif

endmodule
